### rtl/psdo_pkg.sv
// ----------------------------------------------------------------------------
// psdo_pkg: shared types and constants
// Field widths, command codes and register indexes for the pulse oscillator.
// ----------------------------------------------------------------------------
package psdo_pkg;

	localparam int TABLE_SIZE = 1024;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int FRAC_W     = 16;
	localparam int PHASE_W    = IDX_W + FRAC_W;
	localparam int SMP_W      = 16;
	localparam int QUO_W      = FRAC_W + 1;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 36;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_TUNE  = 3'd0,
		REG_GAIN  = 3'd1,
		REG_WIDTH = 3'd2,
		REG_WMIN  = 3'd3,
		REG_WMAX  = 3'd4
	} reg_idx_t;

	// request to the crossing-fraction divider
	typedef struct packed {
		logic               start;
		logic [SMP_W-1:0]   mag;
		logic [SMP_W-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic [QUO_W-1:0]   quo;
	} div_rsp_t;

endpackage

### rtl/pwm_saw_difference_oscillator.sv
// ----------------------------------------------------------------------------
// pwm_saw_difference_oscillator: pulse oscillator from two ramp table reads
// Difference of two interpolated ramp reads, hard sync, gain and saturation.
//
//  channel | dir | beat contents
//  s_      | in  | tuser: command; tdata: rate_in, width_mod, sync_in,
//          |     |        table_index, table_value
//  m_      | out | tdata: sample_out, sync_fraction
//  cfg_    | in  | cfg_index, cfg_data (register write)
//
// An audio sample runs the 17-step divider when sync fires, then four table
// reads through one memory port, which are skipped when the gain is zero.
// Table writes, phase clears and unused commands complete in S_IDLE.
// Reset clears phase, sync history and gain sign and sets the registers to
// their defaults; the table is undefined until written. A waiting result
// holds the block before it writes the next result; cfg_ready is always high.
// ----------------------------------------------------------------------------
module pwm_saw_difference_oscillator import psdo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // rate_in, width_mod, sync_in, table_index, table_value
	input  logic [1:0]  s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // sample_out, sync_fraction
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [25:0] cfg_data
);

	localparam int RD_W = 35;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_GAIN, S_RD0, S_RD1, S_RD2, S_RD3,
		S_M2, S_M2W, S_M3, S_M3W, S_PH, S_DONE
	} state_t;

	state_t state_q;

	logic [23:0]               tune_q;
	logic signed [15:0]        gain_q;
	logic [PHASE_W-1:0]        pw_q, wmin_q, wmax_q;
	logic [PHASE_W-1:0]        phase_q, p2_q;
	logic signed [SMP_W-1:0]   last_sync_q;
	logic                      gneg_q, cross_q;
	logic signed [23:0]        rate_q;
	logic signed [26:0]        wmod_q;
	logic [QUO_W-1:0]          frac_q, frac_out_q;
	logic signed [SMP_W-1:0]   a1_q, b1_q, a2_q, b2_q;
	logic signed [RD_W-1:0]    rd1_q;
	logic signed [RD_W:0]      diff_q;
	logic signed [23:0]        y_q, sample_q;
	logic                      m_tvalid_q;

	logic                      s_acc;
	cmd_t                      cmd;
	logic signed [23:0]        rate_in;
	logic signed [26:0]        width_mod;
	logic signed [SMP_W-1:0]   sync_in;
	logic [IDX_W-1:0]          table_index;
	logic signed [SMP_W-1:0]   table_value;

	div_req_t                  div_req;
	div_rsp_t                  div_rsp;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic [IDX_W-1:0]          raddr;
	logic signed [SMP_W-1:0]   rdata;

	logic signed [27:0]        w_raw;
	logic [PHASE_W-1:0]        w_clamp;
	logic signed [16:0]        g_eff;
	logic signed [RD_W-1:0]    rd2;
	logic signed [29:0]        y_wide;
	logic                      out_free;

	// unpack the input beat
	assign cmd         = cmd_t'(s_tuser);
	assign rate_in     = s_tdata[23:0];
	assign width_mod   = s_tdata[50:24];
	assign sync_in     = s_tdata[66:51];
	assign table_index = s_tdata[76:67];
	assign table_value = s_tdata[92:77];

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// crossing fraction request
	always_comb begin
		div_req.start = s_acc && (cmd == CMD_SAMPLE) && last_sync_q[SMP_W-1] &&
			!sync_in[SMP_W-1];
		div_req.mag   = SMP_W'(-{1'b0, last_sync_q});
		div_req.den   = SMP_W'(-{1'b0, last_sync_q}) + SMP_W'(sync_in);
	end

	psdo_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	psdo_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	psdo_table u_tab (
		.clk   (clk),
		.we    (s_acc && (cmd == CMD_WRITE)),
		.waddr (table_index),
		.wdata (table_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// clamp the modulated width
	always_comb begin
		w_raw = $signed({2'b00, pw_q}) + 28'(wmod_q);
		if (w_raw < $signed({2'b00, wmin_q})) begin
			w_clamp = wmin_q;
		end else if (w_raw > $signed({2'b00, wmax_q})) begin
			w_clamp = wmax_q;
		end else begin
			w_clamp = w_raw[PHASE_W-1:0];
		end
	end

	assign g_eff  = gneg_q ? -17'(gain_q) : 17'(gain_q);
	assign rd2    = $signed({{3{a2_q[15]}}, a2_q, 16'b0}) + RD_W'(mul_p);
	assign y_wide = mul_p[60:31];

	// table address and multiplier operands by step
	always_comb begin
		raddr = phase_q[PHASE_W-1:FRAC_W];
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_RD0: raddr = phase_q[PHASE_W-1:FRAC_W] + IDX_W'(1);
			S_RD1: raddr = p2_q[PHASE_W-1:FRAC_W];
			S_RD2: begin
				raddr = p2_q[PHASE_W-1:FRAC_W] + IDX_W'(1);
				mul_a = MUL_A_W'(17'(b1_q) - 17'(a1_q));
				mul_b = $signed({9'b0, phase_q[FRAC_W-1:0]});
			end
			S_M2: begin
				mul_a = MUL_A_W'(17'(b2_q) - 17'(a2_q));
				mul_b = $signed({9'b0, p2_q[FRAC_W-1:0]});
			end
			S_M3: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = MUL_B_W'(g_eff);
			end
			S_M3W: begin
				mul_a = MUL_A_W'(rate_q);
				mul_b = $signed({1'b0, tune_q});
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tune_q <= 24'd65536;
			gain_q <= 16'sd32767;
			pw_q   <= 26'd33554432;
			wmin_q <= 26'd131072;
			wmax_q <= 26'd66977792;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TUNE:  tune_q <= cfg_data[23:0];
				REG_GAIN:  gain_q <= cfg_data[15:0];
				REG_WIDTH: pw_q   <= cfg_data;
				REG_WMIN:  wmin_q <= cfg_data;
				REG_WMAX:  wmax_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer with state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			last_sync_q <= '0;
			gneg_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// hold the beat until taken, raise it when a result is written
			m_tvalid_q <= (m_tvalid_q && !m_tready) || (state_q == S_DONE && out_free);
			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						unique case (cmd)
							CMD_SAMPLE: begin
								last_sync_q <= sync_in;
								state_q     <= S_DIV;
							end
							CMD_CLEAR: phase_q <= '0;
							default: ;
						endcase
					end
				end
				S_DIV: begin
					if (!div_rsp.busy) begin
						state_q <= S_GAIN;
					end
				end
				S_GAIN:  state_q <= (gain_q == 16'sd0) ? S_DONE : S_RD0;
				S_RD0:   state_q <= S_RD1;
				S_RD1:   state_q <= S_RD2;
				S_RD2:   state_q <= S_RD3;
				S_RD3:   state_q <= S_M2;
				S_M2:    state_q <= S_M2W;
				S_M2W:   state_q <= S_M3;
				S_M3:    state_q <= S_M3W;
				S_M3W:   state_q <= S_PH;
				S_PH: begin
					// take the crossing as new phase, or advance and wrap
					if (frac_q != '0) begin
						phase_q <= PHASE_W'(frac_q);
						gneg_q  <= !gneg_q;
					end else begin
						phase_q <= phase_q + mul_p[PHASE_W+17:18];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_acc && (cmd == CMD_SAMPLE)) begin
			rate_q  <= rate_in;
			wmod_q  <= width_mod;
			cross_q <= div_req.start;
		end
		if (state_q == S_DIV && !div_rsp.busy) begin
			frac_q <= cross_q ? div_rsp.quo : '0;
		end
		if (state_q == S_GAIN) begin
			p2_q <= phase_q + w_clamp;
			y_q  <= '0;
		end
		if (state_q == S_RD0) a1_q <= rdata;
		if (state_q == S_RD1) b1_q <= rdata;
		if (state_q == S_RD2) a2_q <= rdata;
		if (state_q == S_RD3) begin
			b2_q  <= rdata;
			rd1_q <= $signed({{3{a1_q[15]}}, a1_q, 16'b0}) + RD_W'(mul_p);
		end
		if (state_q == S_M2W) begin
			diff_q <= (RD_W+1)'(rd1_q) - (RD_W+1)'(rd2);
		end
		// floor shift by 31 and saturate to 24 bits
		if (state_q == S_M3W) begin
			if (y_wide > 30'sd8388607) begin
				y_q <= 24'sd8388607;
			end else if (y_wide < -30'sd8388608) begin
				y_q <= -24'sd8388608;
			end else begin
				y_q <= y_wide[23:0];
			end
		end
		if (state_q == S_DONE && out_free) begin
			sample_q   <= y_q;
			frac_out_q <= frac_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, frac_out_q, sample_q};

`ifndef NO_ASSERTIONS
	// a sample beat keeps the block busy on the next cycle
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == CMD_SAMPLE) |=> !s_tready)
		else $error("accepted sample did not hold the input");

	// divider only runs while the sequencer waits for it
	a_div_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (state_q == S_DIV))
		else $error("divider busy outside its step");

	// crossing fraction stays within one table step
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[40:24] <= 17'd65536))
		else $error("sync fraction out of range");
`endif

endmodule

### rtl/psdo_divider.sv
// ----------------------------------------------------------------------------
// psdo_divider: crossing fraction divider
// Restoring divider, one quotient bit a cycle: mag * 2^16 / den, with mag <= den.
// ----------------------------------------------------------------------------
module psdo_divider import psdo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [SMP_W-1:0] rem_q;
	logic [SMP_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [4:0]       cnt_q;
	logic             nb_q;
	logic             busy_q;
	logic [SMP_W:0]   trial;
	logic             ge;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, nb_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(QUO_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// upper dividend bits leave mag >> 1 as the first partial remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.mag[SMP_W-1:1]};
			nb_q  <= req.mag[0];
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? SMP_W'(trial - {1'b0, den_q}) : trial[SMP_W-1:0];
			nb_q  <= 1'b0;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quo  = quo_q;

endmodule

### rtl/psdo_mul.sv
// ----------------------------------------------------------------------------
// psdo_mul: shared signed multiplier
// One registered signed product, reused for every multiplication of a sample.
// ----------------------------------------------------------------------------
module psdo_mul import psdo_pkg::*; (
	input  logic                       clk,
	input  logic signed [MUL_A_W-1:0]  a,
	input  logic signed [MUL_B_W-1:0]  b,
	output logic signed [MUL_P_W-1:0]  p
);

	logic signed [MUL_P_W-1:0] p_q;

	// register the product
	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

### rtl/psdo_table.sv
// ----------------------------------------------------------------------------
// psdo_table: ramp table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psdo_table import psdo_pkg::*; (
	input  logic                    clk,
	input  logic                    we,
	input  logic [IDX_W-1:0]        waddr,
	input  logic signed [SMP_W-1:0] wdata,
	input  logic [IDX_W-1:0]        raddr,
	output logic signed [SMP_W-1:0] rdata
);

	logic signed [SMP_W-1:0] mem [TABLE_SIZE];
	logic signed [SMP_W-1:0] rdata_q;

	// write entry, register read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
